### sv/binary_heap_priority_queue_macros.svh
// Assertion macros shared by the heap queue checker.
// No dependencies.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH
// implication checked every clock outside reset
`define BHQ_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication checked outside reset
`define BHQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### sv/bhq_pkg.sv
// Package for the binary heap priority queue: beat types, states, widths.
// No dependencies.
`default_nettype none
package bhq_pkg;
  localparam int DEPTH_DEFAULT = 64;
  localparam int KEY_W = 16;
  localparam int TAG_W = 16;
  localparam int COUNT_W = 7;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_POP    = 2'd1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] entry_key;
    logic [15:0] entry_tag;
  } in_beat_t;

  typedef struct packed {
    logic        top_valid;
    logic [15:0] top_key;
    logic [15:0] top_tag;
    logic [6:0]  entry_count;
    logic        overflow;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POP_RD,
    ST_POP_WR,
    ST_NEXT_PARENT,
    ST_RD_NODE,
    ST_RD_LEFT,
    ST_RD_RIGHT,
    ST_DECIDE,
    ST_SWAP_WR,
    ST_RD_ROOT,
    ST_REPORT,
    ST_OUT
  } bhq_state_t;
endpackage
`default_nettype wire

### sv/binary_heap_priority_queue.sv
// Binary heap priority queue of key/tag pairs in one synchronous RAM.
// Each insert or pop runs a full rebuild, sifting down over every parent; any other
// beat (overflow, pop of an empty heap) only reads the root and reports.
// One beat at a time: a new beat is taken only after the result is accepted.
// Synchronous active-high reset empties the heap and selects max-first order;
// RAM contents are not cleared.
`default_nettype none
module binary_heap_priority_queue import bhq_pkg::*; #(
  parameter int HEAP_DEPTH = DEPTH_DEFAULT
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cfg_we,
  input  wire logic      cfg_wdata,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_beat_t      out_data
);
  localparam int AW = $clog2(HEAP_DEPTH);

  logic order_min_first;
  logic mem_we, we_mux;
  logic [AW-1:0] mem_waddr, mem_raddr, waddr_mux;
  logic [KEY_W+TAG_W-1:0] mem_wdata, mem_rdata, wdata_mux;

  // order register
  always_ff @(posedge clk) begin
    if (rst) order_min_first <= 1'b0;
    else if (cfg_we) order_min_first <= cfg_wdata;
  end

  bhq_ctrl #(.HEAP_DEPTH(HEAP_DEPTH)) u_ctrl (
    .clk, .rst, .order_min_first,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .mem_we, .mem_waddr, .mem_wdata, .mem_raddr, .mem_rdata
  );

  assign we_mux = mem_we;
  assign waddr_mux = mem_waddr;
  assign wdata_mux = mem_wdata;

  bhq_ram #(.WIDTH(KEY_W + TAG_W), .DEPTH(HEAP_DEPTH)) u_store (
    .clk, .we(we_mux), .waddr(waddr_mux), .wdata(wdata_mux),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );
endmodule
`default_nettype wire

### sv/bhq_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### sv/bhq_ctrl.sv
// Heap sequencer: rebuild by sift-down over all parents, using the RAM's read and write port.
// Depends on bhq_pkg and drives one bhq_ram holding {key, tag}.
`default_nettype none
module bhq_ctrl import bhq_pkg::*; #(
  parameter int HEAP_DEPTH = DEPTH_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       order_min_first,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_beat_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_beat_t       out_data,
  output logic            mem_we,
  output logic [$clog2(HEAP_DEPTH)-1:0] mem_waddr,
  output logic [KEY_W+TAG_W-1:0]        mem_wdata,
  output logic [$clog2(HEAP_DEPTH)-1:0] mem_raddr,
  input  wire logic [KEY_W+TAG_W-1:0]   mem_rdata
);
  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int NW = AW + 2;  // room for child indices past the end

  bhq_state_t state, state_next;
  logic [CW-1:0] fill, fill_next;
  logic [NW-1:0] parent, parent_next;   // one past the next parent to sift (counts down)
  logic [NW-1:0] node, node_next;
  logic [NW-1:0] best, best_next;
  logic [KEY_W+TAG_W-1:0] node_ent, node_ent_next;
  logic [KEY_W+TAG_W-1:0] best_ent, best_ent_next;
  logic ovf, ovf_next;
  out_beat_t res, res_next;
  // high in the ST_RD_LEFT cycle right after a swap: the sifted entry is
  // written at its new slot then and taken from node_ent, not the RAM
  logic pend_we;

  logic [NW-1:0] lc, rc, fill_x;
  logic          l_ok, r_ok;
  logic [KEY_W+TAG_W-1:0] cur_ent;

  assign fill_x = NW'(fill);
  assign lc = {node[NW-2:0], 1'b1};
  assign rc = {node[NW-2:0], 1'b0} + NW'(2);
  assign cur_ent = pend_we ? node_ent : mem_rdata;

  // left wins on equal, right only when strictly better
  always_comb begin
    logic [KEY_W-1:0] a, b;
    a = mem_rdata[KEY_W+TAG_W-1:TAG_W];
    b = best_ent[KEY_W+TAG_W-1:TAG_W];
    l_ok = order_min_first ? (a <= b) : (a >= b);
    r_ok = order_min_first ? (a < b) : (a > b);
  end

  // next state and registers
  always_comb begin
    state_next = state;
    fill_next = fill;
    parent_next = parent;
    node_next = node;
    best_next = best;
    node_ent_next = node_ent;
    best_ent_next = best_ent;
    ovf_next = ovf;
    res_next = res;
    case (state)
      ST_IDLE: if (in_valid) begin
        ovf_next = 1'b0;
        if (in_data.mode == MODE_INSERT) begin
          if (fill == CW'(HEAP_DEPTH)) begin
            ovf_next = 1'b1;
            state_next = ST_RD_ROOT;
          end else begin
            fill_next = fill + CW'(1);
            parent_next = NW'(fill + CW'(1)) >> 1;
            state_next = ST_NEXT_PARENT;
          end
        end else if (in_data.mode == MODE_POP && fill != '0) begin
          fill_next = fill - CW'(1);
          state_next = ST_POP_RD;
        end else begin
          state_next = ST_RD_ROOT;
        end
      end
      ST_POP_RD: state_next = ST_POP_WR;
      ST_POP_WR: begin
        parent_next = fill_x >> 1;
        state_next = ST_NEXT_PARENT;
      end
      ST_NEXT_PARENT: begin
        if (parent == '0) state_next = ST_RD_ROOT;
        else begin
          parent_next = parent - NW'(1);
          node_next = parent - NW'(1);
          state_next = ST_RD_NODE;
        end
      end
      ST_RD_NODE: state_next = ST_RD_LEFT;
      ST_RD_LEFT: begin
        node_ent_next = cur_ent;
        best_ent_next = cur_ent;
        best_next = node;
        state_next = (lc < fill_x) ? ST_RD_RIGHT : ST_NEXT_PARENT;
      end
      ST_RD_RIGHT: begin
        if (l_ok) begin
          best_next = lc;
          best_ent_next = mem_rdata;
        end
        state_next = (rc < fill_x) ? ST_DECIDE : ST_SWAP_WR;
      end
      ST_DECIDE: begin
        if (r_ok) begin
          best_next = rc;
          best_ent_next = mem_rdata;
        end
        state_next = ST_SWAP_WR;
      end
      ST_SWAP_WR: begin
        // best entry written into node here; node entry lands at best next cycle
        if (best == node) state_next = ST_NEXT_PARENT;
        else begin
          node_next = best;
          state_next = ST_RD_LEFT;
        end
      end
      ST_RD_ROOT: state_next = ST_REPORT;
      ST_REPORT: begin
        res_next.top_valid = (fill != '0);
        res_next.top_key = (fill != '0) ? mem_rdata[KEY_W+TAG_W-1:TAG_W] : '0;
        res_next.top_tag = (fill != '0) ? mem_rdata[TAG_W-1:0] : '0;
        res_next.entry_count = COUNT_W'(fill);
        res_next.overflow = ovf;
        state_next = ST_OUT;
      end
      ST_OUT: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // memory and handshake outputs
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    in_ready = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    out_data = res;
    case (state)
      ST_IDLE: if (in_valid && in_data.mode == MODE_INSERT
                   && fill != CW'(HEAP_DEPTH)) begin
        mem_we = 1'b1;
        mem_waddr = AW'(fill);
        mem_wdata = {in_data.entry_key, in_data.entry_tag};
      end
      ST_POP_RD: mem_raddr = AW'(fill);
      ST_POP_WR: begin
        mem_we = 1'b1;
        mem_waddr = '0;
        mem_wdata = mem_rdata;
      end
      ST_NEXT_PARENT: mem_raddr = AW'(parent - NW'(1));
      ST_RD_NODE: mem_raddr = AW'(node);
      ST_RD_LEFT: begin
        mem_raddr = AW'(lc);
        // second half of the swap: sifted entry into its new slot
        if (pend_we) begin
          mem_we = 1'b1;
          mem_waddr = AW'(node);
          mem_wdata = node_ent;
        end
      end
      ST_RD_RIGHT: mem_raddr = AW'(rc);
      ST_SWAP_WR: if (best != node) begin
        mem_we = 1'b1;
        mem_waddr = AW'(node);
        mem_wdata = best_ent;
      end
      ST_RD_ROOT: mem_raddr = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill <= '0;
      pend_we <= 1'b0;
    end else begin
      state <= state_next;
      fill <= fill_next;
      pend_we <= (state == ST_SWAP_WR) && (best != node);
    end
    parent <= parent_next;
    node <= node_next;
    best <= best_next;
    node_ent <= node_ent_next;
    best_ent <= best_ent_next;
    ovf <= ovf_next;
    res <= res_next;
  end
endmodule
`default_nettype wire

### sv/bhq_checker.sv
// Port-level checker for the heap queue, bound to the top level.
// Depends on bhq_pkg and the assertion macro header.
`default_nettype none
`include "binary_heap_priority_queue_macros.svh"
module bhq_port_props import bhq_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_beat_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_beat_t out_data
);
  `BHQ_ASSERT(a_empty_zero, out_valid && !out_data.top_valid, out_data.top_key == '0 && out_data.top_tag == '0, "empty result carries data")
  `BHQ_ASSERT(a_count_valid, out_valid, out_data.top_valid == (out_data.entry_count != '0), "top_valid disagrees with count")
  `BHQ_ASSERT(a_one_at_time, out_valid, !in_ready, "input taken while result pending")
  `BHQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
endmodule
bind binary_heap_priority_queue bhq_port_props u_chk (
  .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
);
`default_nettype wire
